FILE: src/cng_pkg.sv
// ----------------------------------------------------------------------------
// cng_pkg: shared types and constants of the colored noise generator
// Register map, configuration struct, shared multiplier widths and the fixed
// filter coefficients (signed, 24 fraction bits).
// ----------------------------------------------------------------------------
package cng_pkg;

  // APB register map, word index = paddr[4:2]
  localparam int AddrW = 5;
  localparam logic [2:0] RegColor    = 3'd0;
  localparam logic [2:0] RegHoldInc  = 3'd1;
  localparam logic [2:0] RegGlide    = 3'd2;
  localparam logic [2:0] RegSmooth   = 3'd3;
  localparam logic [2:0] RegLevel    = 3'd4;
  localparam logic [2:0] RegCutoff   = 3'd5;
  localparam logic [2:0] RegSeed     = 3'd6;

  typedef struct packed {
    logic [16:0] color;
    logic [23:0] hold_inc;
    logic [16:0] glide;
    logic [16:0] smooth;
    logic [16:0] level_tgt;
    logic [15:0] cutoff_tgt;
    logic [31:0] seed;
  } cfg_t;

  // register reset values and the color midpoint
  localparam logic [16:0] Unity16     = 17'd65536;
  localparam logic [16:0] Half16      = 17'd32768;
  localparam logic [15:0] CutoffReset = 16'd20000;
  localparam logic [31:0] SeedReset   = 32'd1;

  // shared multiplier: signed A x signed B
  localparam int MulAW = 33;
  localparam int MulBW = 26;
  localparam int ProdW = MulAW + MulBW;

  localparam logic signed [MulBW-1:0] LcgMul = 26'sd1664525;
  localparam logic [31:0]             LcgAdd = 32'd1013904223;

  localparam logic signed [MulBW-1:0] KPoleA      = 26'sd16737790;
  localparam logic signed [MulBW-1:0] KInA        = 26'sd1661716;
  localparam logic signed [MulBW-1:0] KPoleB      = 26'sd16156459;
  localparam logic signed [MulBW-1:0] KInB        = 26'sd4974720;
  localparam logic signed [MulBW-1:0] KPoleC      = 26'sd9563013;
  localparam logic signed [MulBW-1:0] KInC        = 26'sd17661229;
  localparam logic signed [MulBW-1:0] KDirect     = 26'sd3100430;
  localparam logic signed [MulBW-1:0] KBrownIn    = 26'sd335544;
  localparam logic signed [MulBW-1:0] KBrownRecip = 26'sd16448251;

endpackage

FILE: src/cng_regs.sv
// ----------------------------------------------------------------------------
// cng_regs: configuration register file
// APB-style write/read of the seven control registers; flags a seed write
// in the following cycle so the generator can reload.
// ----------------------------------------------------------------------------
module cng_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cng_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output cng_pkg::cfg_t             cfg_o,
  output logic                      seed_load_o
);

  cng_pkg::cfg_t cfg_q;
  logic          seed_load_q;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign reg_idx = paddr[cng_pkg::AddrW-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color      <= '0;
      cfg_q.hold_inc   <= '0;
      cfg_q.glide      <= cng_pkg::Unity16;
      cfg_q.smooth     <= cng_pkg::Unity16;
      cfg_q.level_tgt  <= cng_pkg::Unity16;
      cfg_q.cutoff_tgt <= cng_pkg::CutoffReset;
      cfg_q.seed       <= cng_pkg::SeedReset;
      seed_load_q      <= 1'b0;
    end else begin
      seed_load_q <= wr_en && (reg_idx == cng_pkg::RegSeed);
      if (wr_en) begin
        case (reg_idx)
          cng_pkg::RegColor:   cfg_q.color      <= pwdata[16:0];
          cng_pkg::RegHoldInc: cfg_q.hold_inc   <= pwdata[23:0];
          cng_pkg::RegGlide:   cfg_q.glide      <= pwdata[16:0];
          cng_pkg::RegSmooth:  cfg_q.smooth     <= pwdata[16:0];
          cng_pkg::RegLevel:   cfg_q.level_tgt  <= pwdata[16:0];
          cng_pkg::RegCutoff:  cfg_q.cutoff_tgt <= pwdata[15:0];
          cng_pkg::RegSeed:    cfg_q.seed       <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      cng_pkg::RegColor:   prdata = {15'b0, cfg_q.color};
      cng_pkg::RegHoldInc: prdata = {8'b0, cfg_q.hold_inc};
      cng_pkg::RegGlide:   prdata = {15'b0, cfg_q.glide};
      cng_pkg::RegSmooth:  prdata = {15'b0, cfg_q.smooth};
      cng_pkg::RegLevel:   prdata = {15'b0, cfg_q.level_tgt};
      cng_pkg::RegCutoff:  prdata = {16'b0, cfg_q.cutoff_tgt};
      cng_pkg::RegSeed:    prdata = cfg_q.seed;
      default:             prdata = '0;
    endcase
  end

  assign cfg_o       = cfg_q;
  assign seed_load_o = seed_load_q;

endmodule

FILE: src/cng_mul.sv
// ----------------------------------------------------------------------------
// cng_mul: shared signed multiplier
// One registered signed product per cycle for the sample sequencer.
// ----------------------------------------------------------------------------
module cng_mul (
  input  logic                             clk_i,
  input  logic signed [cng_pkg::MulAW-1:0] a_i,
  input  logic signed [cng_pkg::MulBW-1:0] b_i,
  output logic signed [cng_pkg::ProdW-1:0] prod_o
);

  logic signed [cng_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

FILE: src/colored_noise_generator.sv
// ----------------------------------------------------------------------------
// colored_noise_generator: white / pink / brown noise morph with hold
// One sample at a time: a new input transfer is taken only when idle, once the
// previous result has been pushed out; an 18-step sequencer runs every product
// through one shared 33x26 multiplier.
// Reset: registers take their defaults, the generator loads seed 1, filter
// and hold state clear, level and cutoff sit at their targets.
// ----------------------------------------------------------------------------
module colored_noise_generator #(
  parameter int SAMPLE_BITS = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cng_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] noise_out_o,
  output logic signed [SAMPLE_BITS-1:0] held_value_o,
  output logic [16:0]                   level_now_o,
  output logic [15:0]                   cutoff_now_o
);

  localparam int ProdW    = cng_pkg::ProdW;
  localparam int AccW     = ProdW + 1;
  localparam int MixShift = 43 - SAMPLE_BITS;
  localparam logic signed [31:0] SMax = (32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1;
  localparam logic signed [31:0] SMin = -(32'sd1 <<< (SAMPLE_BITS - 1));
  localparam logic [AccW-1:0]  MixHalf  = AccW'(1) << (MixShift - 1);
  localparam logic [AccW-1:0]  AccHalf  = AccW'(1) << 23;
  localparam logic [ProdW-1:0] ProdH24  = ProdW'(1) << 23;
  localparam logic [ProdW-1:0] ProdH16  = ProdW'(1) << 15;

  // sequencer
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StPush = 2'd2;

  localparam logic [4:0] StepSeed      = 5'd0;
  localparam logic [4:0] StepWhite     = 5'd1;
  localparam logic [4:0] StepCutoff    = 5'd2;
  localparam logic [4:0] StepPaIn      = 5'd3;
  localparam logic [4:0] StepPaDone    = 5'd4;
  localparam logic [4:0] StepPbIn      = 5'd5;
  localparam logic [4:0] StepPbDone    = 5'd6;
  localparam logic [4:0] StepPcIn      = 5'd7;
  localparam logic [4:0] StepPcDone    = 5'd8;
  localparam logic [4:0] StepPink      = 5'd9;
  localparam logic [4:0] StepBrownIn   = 5'd10;
  localparam logic [4:0] StepLevel     = 5'd11;
  localparam logic [4:0] StepBrownDone = 5'd12;
  localparam logic [4:0] StepMixB      = 5'd13;
  localparam logic [4:0] StepNoise     = 5'd14;
  localparam logic [4:0] StepHold      = 5'd15;
  localparam logic [4:0] StepGlide     = 5'd16;
  localparam logic [4:0] StepHoldDone  = 5'd17;

  function automatic logic [16:0] cap16(input logic [16:0] v);
    return (v > cng_pkg::Unity16) ? cng_pkg::Unity16 : v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sd2147483647;
    lo = -36'sd2147483648;
    if (v > hi) return 32'sh7FFFFFFF;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  cng_pkg::cfg_t cfg;
  logic          seed_load;

  cng_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .seed_load_o (seed_load)
  );

  // control and filter state
  logic [1:0]                    state_q;
  logic [4:0]                    step_q;
  logic [31:0]                   lcg_q;
  logic signed [31:0]            pa_q, pb_q, pc_q, brown_q;
  logic [23:0]                   hold_phase_q;
  logic signed [SAMPLE_BITS-1:0] hold_target_q, hold_now_q;
  logic [23:0]                   cutoff_acc_q;
  logic [16:0]                   level_acc_q;
  logic                          out_valid_q;

  // working registers
  logic signed [ProdW-1:0]       acc_q;
  logic signed [24:0]            diff_q;
  logic signed [23:0]            w_q;
  logic signed [33:0]            pink_q;
  logic signed [31:0]            p_q;
  logic signed [SAMPLE_BITS-1:0] noise_q;
  logic                          mix_hi_q;
  logic [16:0]                   coef1_q;
  logic [19:0]                   coef2_q;
  logic signed [SAMPLE_BITS-1:0] noise_out_q, held_value_q;
  logic [16:0]                   level_now_q;
  logic [15:0]                   cutoff_now_q;

  // shared multiplier
  logic signed [cng_pkg::MulAW-1:0] mul_a;
  logic signed [cng_pkg::MulBW-1:0] mul_b;
  logic signed [ProdW-1:0]          prod;

  cng_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  logic [16:0] smooth_cap, glide_cap, level_cap, color_cap;
  assign smooth_cap = cap16(cfg.smooth);
  assign glide_cap  = cap16(cfg.glide);
  assign level_cap  = cap16(cfg.level_tgt);
  assign color_cap  = cap16(cfg.color);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == StRun) begin
      case (step_q)
        StepSeed: begin
          mul_a = $signed({1'b0, lcg_q});
          mul_b = cng_pkg::LcgMul;
        end
        StepWhite, StepBrownIn: begin
          mul_a = 33'(diff_q);
          mul_b = $signed({9'b0, smooth_cap});
        end
        StepCutoff: begin
          mul_a = 33'(pa_q);
          mul_b = cng_pkg::KPoleA;
        end
        StepPaIn: begin
          mul_a = 33'(w_q);
          mul_b = cng_pkg::KInA;
        end
        StepPaDone: begin
          mul_a = 33'(pb_q);
          mul_b = cng_pkg::KPoleB;
        end
        StepPbIn: begin
          mul_a = 33'(w_q);
          mul_b = cng_pkg::KInB;
        end
        StepPbDone: begin
          mul_a = 33'(pc_q);
          mul_b = cng_pkg::KPoleC;
        end
        StepPcIn: begin
          mul_a = 33'(w_q);
          mul_b = cng_pkg::KInC;
        end
        StepPcDone: begin
          mul_a = 33'(w_q);
          mul_b = cng_pkg::KDirect;
        end
        StepPink: begin
          mul_a = 33'(w_q);
          mul_b = cng_pkg::KBrownIn;
        end
        StepLevel: begin
          mul_a = 33'(brown_q);
          mul_b = cng_pkg::KBrownRecip;
        end
        StepBrownDone: begin
          mul_a = mix_hi_q ? 33'(p_q) : 33'(w_q);
          mul_b = $signed({9'b0, coef1_q});
        end
        StepMixB: begin
          mul_a = mix_hi_q ? 33'(brown_q) : 33'(p_q);
          mul_b = $signed({6'b0, coef2_q});
        end
        StepGlide: begin
          mul_a = 33'(diff_q);
          mul_b = $signed({9'b0, glide_cap});
        end
        default: ;
      endcase
    end
  end

  // product rounding, round half up
  logic [ProdW-1:0]   prod_h24, prod_h16;
  logic signed [34:0] prod_r24;
  logic signed [31:0] prod_r16;
  assign prod_h24 = prod + ProdH24;
  assign prod_h16 = prod + ProdH16;
  assign prod_r24 = $signed(prod_h24[ProdW-1:24]);
  assign prod_r16 = $signed(prod_h16[47:16]);

  // pole: state*k + w*kin, accumulated over two products
  logic [AccW-1:0]    pole_sum;
  logic signed [31:0] pole_new;
  assign pole_sum = {acc_q[ProdW-1], acc_q} + {prod[ProdW-1], prod} + AccHalf;
  assign pole_new = sat32($signed(pole_sum[AccW-1:24]));

  logic signed [35:0] pink_sum, brown_sum;
  logic signed [34:0] p_sum;
  assign pink_sum  = 36'(pa_q) + 36'(pb_q) + 36'(pc_q) + 36'(prod_r24);
  assign brown_sum = 36'(brown_q) + 36'(prod_r24);
  assign p_sum     = 35'(pink_q) + 35'sd2;

  // generator step
  logic [31:0] lcg_next;
  assign lcg_next = prod[31:0] + cng_pkg::LcgAdd;

  // morph weights
  logic        mix_hi;
  logic [16:0] mix_t;
  logic [19:0] mix_t10;
  assign mix_hi  = color_cap > cng_pkg::Half16;
  assign mix_t   = mix_hi ? {color_cap[15:0] - cng_pkg::Half16[15:0], 1'b0}
                          : {color_cap[15:0], 1'b0};
  assign mix_t10 = {mix_t, 3'b0} + {2'b0, mix_t, 1'b0};

  // mix rounding and saturation
  logic signed [AccW-1:0]        mix_sum, mix_sh;
  logic signed [SAMPLE_BITS-1:0] noise_d;
  assign mix_sum = $signed({acc_q[ProdW-1], acc_q} + {prod[ProdW-1], prod} + MixHalf);
  assign mix_sh  = mix_sum >>> MixShift;

  always_comb begin
    if (mix_sh > AccW'(SMax)) noise_d = SMax[SAMPLE_BITS-1:0];
    else if (mix_sh < AccW'(SMin)) noise_d = SMin[SAMPLE_BITS-1:0];
    else noise_d = mix_sh[SAMPLE_BITS-1:0];
  end

  // one-pole followers
  logic signed [31:0]            cut_sum, level_sum, hold_sum;
  logic [23:0]                   cutoff_d;
  logic [16:0]                   level_d;
  logic signed [SAMPLE_BITS-1:0] hold_now_d;
  assign cut_sum   = $signed({8'b0, cutoff_acc_q}) + prod_r16;
  assign level_sum = $signed({15'b0, level_acc_q}) + prod_r16;
  assign hold_sum  = 32'(hold_now_q) + prod_r16;

  always_comb begin
    if (cut_sum < 32'sd0) cutoff_d = '0;
    else if (cut_sum > 32'sh00FFFFFF) cutoff_d = 24'hFFFFFF;
    else cutoff_d = cut_sum[23:0];

    if (level_sum < 32'sd0) level_d = '0;
    else if (level_sum > $signed({15'b0, cng_pkg::Unity16})) level_d = cng_pkg::Unity16;
    else level_d = level_sum[16:0];

    if (hold_sum > SMax) hold_now_d = SMax[SAMPLE_BITS-1:0];
    else if (hold_sum < SMin) hold_now_d = SMin[SAMPLE_BITS-1:0];
    else hold_now_d = hold_sum[SAMPLE_BITS-1:0];
  end

  // hold phase: a carry out of 24 bits latches the new sample
  logic [24:0]                   phase_sum;
  logic signed [SAMPLE_BITS-1:0] hold_tgt_d;
  assign phase_sum  = {1'b0, hold_phase_q} + {1'b0, cfg.hold_inc};
  assign hold_tgt_d = phase_sum[24] ? noise_q : hold_target_q;

  logic in_xfer, push_go;
  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign push_go    = (state_q == StPush) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      step_q        <= StepSeed;
      lcg_q         <= cng_pkg::SeedReset;
      pa_q          <= '0;
      pb_q          <= '0;
      pc_q          <= '0;
      brown_q       <= '0;
      hold_phase_q  <= '0;
      hold_target_q <= '0;
      hold_now_q    <= '0;
      cutoff_acc_q  <= {cng_pkg::CutoffReset, 8'b0};
      level_acc_q   <= cng_pkg::Unity16;
      out_valid_q   <= 1'b0;
    end else begin
      if (seed_load) lcg_q <= cfg.seed;

      if (push_go) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            state_q <= StRun;
            step_q  <= StepSeed;
            if (restart_i) begin
              pa_q          <= '0;
              pb_q          <= '0;
              pc_q          <= '0;
              brown_q       <= '0;
              hold_phase_q  <= '0;
              hold_target_q <= '0;
              hold_now_q    <= '0;
              level_acc_q   <= level_cap;
              cutoff_acc_q  <= {cfg.cutoff_tgt, 8'b0};
            end
          end
        end
        StRun: begin
          step_q <= step_q + 5'd1;
          case (step_q)
            StepWhite:     lcg_q <= lcg_next;
            StepCutoff:    cutoff_acc_q <= cutoff_d;
            StepPaDone:    pa_q <= pole_new;
            StepPbDone:    pb_q <= pole_new;
            StepPcDone:    pc_q <= pole_new;
            StepBrownIn:   brown_q <= sat32(brown_sum);
            StepLevel:     level_acc_q <= level_d;
            StepBrownDone: brown_q <= sat32(36'(prod_r24));
            StepHold: begin
              hold_phase_q  <= phase_sum[23:0];
              hold_target_q <= hold_tgt_d;
            end
            StepHoldDone: begin
              hold_now_q <= hold_now_d;
              state_q    <= StPush;
            end
            default: ;
          endcase
        end
        StPush: begin
          if (push_go) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == StRun) begin
      case (step_q)
        StepSeed: begin
          diff_q   <= $signed({1'b0, cfg.cutoff_tgt, 8'b0}) - $signed({1'b0, cutoff_acc_q});
          mix_hi_q <= mix_hi;
          coef1_q  <= cng_pkg::Unity16 - mix_t;
          coef2_q  <= mix_hi ? mix_t10 : {3'b0, mix_t};
        end
        StepWhite: begin
          w_q    <= $signed({~lcg_next[31], lcg_next[30:8]});
          diff_q <= $signed({8'b0, level_cap}) - $signed({8'b0, level_acc_q});
        end
        StepPaIn, StepPbIn, StepPcIn, StepMixB: acc_q <= prod;
        StepPink:    pink_q <= pink_sum[33:0];
        StepBrownIn: p_q <= $signed(p_sum[33:2]);
        StepNoise:   noise_q <= noise_d;
        StepHold:    diff_q <= 25'(hold_tgt_d) - 25'(hold_now_q);
        default: ;
      endcase
    end
    if (push_go) begin
      noise_out_q  <= noise_q;
      held_value_q <= hold_now_q;
      level_now_q  <= level_acc_q;
      cutoff_now_q <= cutoff_acc_q[23:8];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign noise_out_o  = noise_out_q;
  assign held_value_o = held_value_q;
  assign level_now_o  = level_now_q;
  assign cutoff_now_o = cutoff_now_q;

  // sequencer never runs past its last step
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (step_q <= StepHoldDone))
    else $error("sequencer step out of range");

  // an input transfer always starts the sequence at the first step
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == StRun) && (step_q == StepSeed))
    else $error("input transfer did not start the sequence");

  // smoothed gain stays within unity
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_acc_q <= cng_pkg::Unity16)
    else $error("level accumulator above unity");

  // a result only appears from the push state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StPush))
    else $error("result raised outside push state");

endmodule

FILE: bench/cng_sample_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cng_sample_checker: bit-exact tracker of the colored noise generator
// Follows register writes on the APB port and every tick transfer, computes
// the noise, hold, level and cutoff values each tick must produce, and
// compares them in order against the samples the block hands out.
// ----------------------------------------------------------------------------
module cng_sample_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic                      pready_i,
  input  logic [cng_pkg::AddrW-1:0] paddr_i,
  input  logic [31:0]               pwdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      restart_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [17:0]        noise_out_i,
  input  logic signed [17:0]        held_value_i,
  input  logic [16:0]               level_now_i,
  input  logic [15:0]               cutoff_now_i,
  output int                        err_count_o,
  output int                        pending_o
);

  localparam int     FracBits = 14;
  localparam longint SMax     = 131071;
  localparam longint SMin     = -131072;
  localparam longint I32Max   = 64'sd2147483647;
  localparam longint I32Min   = -64'sd2147483648;
  localparam longint Unity    = 65536;

  // filter coefficients, signed with 24 fraction bits
  localparam longint PoleA      = 16737790;
  localparam longint FeedA      = 1661716;
  localparam longint PoleB      = 16156459;
  localparam longint FeedB      = 4974720;
  localparam longint PoleC      = 9563013;
  localparam longint FeedC      = 17661229;
  localparam longint DirectGain = 3100430;
  localparam longint BrownFeed  = 335544;
  localparam longint BrownLeak  = 16448251;

  typedef struct packed {
    logic signed [17:0] noise;
    logic signed [17:0] held;
    logic [16:0]        level;
    logic [15:0]        cutoff;
  } noise_sample_t;

  // register copy
  logic [16:0] color, glide, smooth, level_tgt;
  logic [23:0] hold_inc;
  logic [15:0] cutoff_tgt;
  logic [31:0] seed;

  // generator and filter state
  logic [31:0] lcg;
  longint      pole_a, pole_b, pole_c, brown;
  logic [23:0] hold_phase;
  longint      hold_target, hold_now, cutoff_acc, level_acc;

  noise_sample_t expected_samples[$];

  // round half up, floor(v / 2^s + 1/2)
  function automatic longint round_shift(longint v, int unsigned s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint unity_cap(logic [16:0] v);
    return (v > 17'd65536) ? Unity : longint'(v);
  endfunction

  function automatic longint glide_toward(longint now, longint target, logic [16:0] coef);
    return now + round_shift((target - now) * unity_cap(coef), 16);
  endfunction

  function automatic longint pole_step(longint st, longint k, longint w, longint kin);
    return clip(round_shift(st * k + w * kin, 24), I32Min, I32Max);
  endfunction

  task automatic clear_filters();
    pole_a      = 0;
    pole_b      = 0;
    pole_c      = 0;
    brown       = 0;
    hold_phase  = '0;
    hold_target = 0;
    hold_now    = 0;
    level_acc   = unity_cap(level_tgt);
    cutoff_acc  = longint'(cutoff_tgt) <<< 8;
  endtask

  task automatic load_defaults();
    color      = '0;
    hold_inc   = '0;
    glide      = 17'd65536;
    smooth     = 17'd65536;
    level_tgt  = 17'd65536;
    cutoff_tgt = 16'd20000;
    seed       = 32'd1;
    lcg        = seed;
    clear_filters();
  endtask

  task automatic write_register(logic [2:0] idx, logic [31:0] data);
    case (idx)
      cng_pkg::RegColor:   color      = data[16:0];
      cng_pkg::RegHoldInc: hold_inc   = data[23:0];
      cng_pkg::RegGlide:   glide      = data[16:0];
      cng_pkg::RegSmooth:  smooth     = data[16:0];
      cng_pkg::RegLevel:   level_tgt  = data[16:0];
      cng_pkg::RegCutoff:  cutoff_tgt = data[15:0];
      cng_pkg::RegSeed: begin
        seed = data;
        lcg  = data;
      end
      default: ;
    endcase
  endtask

  task automatic compute_noise_sample(input logic restart, output noise_sample_t s);
    longint      w, pink, p, b, c, t, mix, noise;
    logic [24:0] phase_sum;
    if (restart) clear_filters();
    lcg = lcg * 32'd1664525 + 32'd1013904223;
    w   = longint'(lcg[31:8]) - 64'sd8388608;

    pole_a = pole_step(pole_a, PoleA, w, FeedA);
    pole_b = pole_step(pole_b, PoleB, w, FeedB);
    pole_c = pole_step(pole_c, PoleC, w, FeedC);
    pink   = pole_a + pole_b + pole_c + round_shift(w * DirectGain, 24);

    brown = clip(brown + round_shift(w * BrownFeed, 24), I32Min, I32Max);
    brown = clip(round_shift(brown * BrownLeak, 24), I32Min, I32Max);

    p = round_shift(pink, 2);
    b = brown * 10;
    c = unity_cap(color);
    // lower half fades white into pink, upper half pink into brown
    if (c <= 32768) begin
      t   = c * 2;
      mix = w * (Unity - t) + p * t;
    end else begin
      t   = (c - 32768) * 2;
      mix = p * (Unity - t) + b * t;
    end
    noise = clip(round_shift(mix, 39 - FracBits), SMin, SMax);

    phase_sum  = {1'b0, hold_phase} + {1'b0, hold_inc};
    hold_phase = phase_sum[23:0];
    if (phase_sum[24]) hold_target = noise;
    hold_now = clip(glide_toward(hold_now, hold_target, glide), SMin, SMax);

    cutoff_acc = clip(glide_toward(cutoff_acc, longint'(cutoff_tgt) <<< 8, smooth),
                      0, 64'sd16777215);
    level_acc  = clip(glide_toward(level_acc, unity_cap(level_tgt), smooth), 0, Unity);

    s.noise  = noise[17:0];
    s.held   = hold_now[17:0];
    s.level  = level_acc[16:0];
    s.cutoff = cutoff_acc[23:8];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    noise_sample_t exp_s, new_s;
    if (!rst_ni) begin
      load_defaults();
      expected_samples.delete();
      err_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("sample transfer with nothing expected");
          err_count_o++;
        end else begin
          exp_s = expected_samples.pop_front();
          if (noise_out_i !== exp_s.noise) begin
            $error("noise_out: expected %0d, got %0d", exp_s.noise, noise_out_i);
            err_count_o++;
          end
          if (held_value_i !== exp_s.held) begin
            $error("held_value: expected %0d, got %0d", exp_s.held, held_value_i);
            err_count_o++;
          end
          if (level_now_i !== exp_s.level) begin
            $error("level_now: expected %0d, got %0d", exp_s.level, level_now_i);
            err_count_o++;
          end
          if (cutoff_now_i !== exp_s.cutoff) begin
            $error("cutoff_now: expected %0d, got %0d", exp_s.cutoff, cutoff_now_i);
            err_count_o++;
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) write_register(paddr_i[4:2], pwdata_i);
      if (in_valid_i && in_ready_i) begin
        compute_noise_sample(restart_i, new_s);
        expected_samples.push_back(new_s);
      end
    end
    pending_o = expected_samples.size();
  end

endmodule

FILE: bench/colored_noise_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// colored_noise_generator_tb: randomized check of the noise generator
// Directed ticks at register extremes, then phases of random settings with
// random restarts, idle and stall patterns and one long output hold-off;
// every sample is compared by cng_sample_checker.
// ----------------------------------------------------------------------------
module colored_noise_generator_tb;

  localparam logic [2:0] RegSpare    = 3'd7;  // not mapped, writes are dropped
  localparam int         CycleLimit  = 400000;
  localparam int         RandPhases  = 10;
  localparam int         PhaseTicks  = 103;
  localparam int         HoldoffLen  = 400;

  logic                      clk_i, rst_ni;
  logic                      psel, penable, pwrite, pready;
  logic [cng_pkg::AddrW-1:0] paddr;
  logic [31:0]               pwdata, prdata;
  logic                      in_valid_i, in_ready_o, restart_i;
  logic                      out_valid_o, out_ready_i;
  logic signed [17:0]        noise_out_o, held_value_o;
  logic [16:0]               level_now_o;
  logic [15:0]               cutoff_now_o;

  int   err_count, pending;
  int   send_idle_pct, recv_stall_pct;
  logic holdoff_go, holdoff_done;

  colored_noise_generator dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .restart_i,
    .out_valid_o, .out_ready_i,
    .noise_out_o, .held_value_o, .level_now_o, .cutoff_now_o
  );

  cng_sample_checker checker_i (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .in_valid_i, .in_ready_i(in_ready_o), .restart_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .noise_out_i(noise_out_o), .held_value_i(held_value_o),
    .level_now_i(level_now_o), .cutoff_now_i(cutoff_now_o),
    .err_count_o(err_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("colored_noise_generator_tb: done, errors");
    $finish;
  end

  // sample receiver, with one long hold-off on request
  initial begin
    out_ready_i  = 1'b0;
    holdoff_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_go && !holdoff_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldoffLen) @(negedge clk_i);
        holdoff_done = 1'b1;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // register write, unused upper data bits carry noise
  task automatic write_reg(logic [2:0] idx, logic [31:0] value, int width);
    logic [31:0] keep;
    keep = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 1);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (value & keep) | ($urandom() & ~keep);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_regs(logic [16:0] color, logic [23:0] hold_inc, logic [16:0] glide,
                              logic [16:0] smooth, logic [16:0] level, logic [15:0] cutoff,
                              logic [31:0] seed);
    write_reg(cng_pkg::RegColor, 32'(color), 17);
    write_reg(cng_pkg::RegHoldInc, 32'(hold_inc), 24);
    write_reg(cng_pkg::RegGlide, 32'(glide), 17);
    write_reg(cng_pkg::RegSmooth, 32'(smooth), 17);
    write_reg(cng_pkg::RegLevel, 32'(level), 17);
    write_reg(cng_pkg::RegCutoff, 32'(cutoff), 16);
    write_reg(cng_pkg::RegSeed, seed, 32);
  endtask

  // returns at the rising edge of the transfer
  task automatic send_tick(logic restart);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  function automatic logic [16:0] pick_coef();
    case ($urandom_range(4))
      0:       return 17'd0;
      1:       return 17'd65536;
      2:       return 17'($urandom_range(1, 4096));
      3:       return 17'($urandom_range(131071));
      default: return 17'($urandom_range(1, 65536));
    endcase
  endfunction

  function automatic logic [16:0] pick_color();
    case ($urandom_range(5))
      0:       return 17'd0;
      1:       return 17'd32768;
      2:       return 17'd65536;
      3:       return 17'($urandom_range(131071));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [23:0] pick_hold_inc();
    case ($urandom_range(3))
      0:       return 24'd0;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom());
      default: return 24'($urandom_range(1 << 16, 1 << 22));
    endcase
  endfunction

  initial begin
    logic [16:0] level;
    logic [15:0] cutoff;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    restart_i      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_go     = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, restart twice on a running filter
    for (int i = 0; i < 8; i++) send_tick(i == 2 || i == 6);
    drain();

    // pink midpoint, fastest hold wrap, slowest glide and smoothing
    program_regs(17'd32768, 24'hFFFFFF, 17'd1, 17'd1, 17'd0, 16'd65535, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) send_tick(i == 3);
    drain();

    // factors above range, frozen glide and smoothing, zero seed
    program_regs(17'd131071, 24'h800000, 17'd0, 17'd0, 17'd131071, 16'd0, 32'd0);
    write_reg(RegSpare, $urandom(), 32);
    for (int i = 0; i < 8; i++) send_tick(i == 0 || i == 5);
    drain();

    for (int ph = 0; ph < RandPhases; ph++) begin
      case ($urandom_range(2))
        0:       level = 17'd0;
        1:       level = 17'd65536;
        default: level = 17'($urandom_range(131071));
      endcase
      cutoff = ($urandom_range(3) == 0) ? 16'd65535 : 16'($urandom());
      program_regs(pick_color(), pick_hold_inc(), pick_coef(), pick_coef(),
                   level, cutoff, $urandom());
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 65;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 65;
        end
        default: begin
          send_idle_pct  = 22;
          recv_stall_pct = 22;
        end
      endcase
      // one long output hold-off while ticks keep coming
      if (ph == 4) holdoff_go = 1'b1;
      for (int i = 0; i < PhaseTicks; i++) send_tick($urandom_range(15) == 0);
      drain();
    end

    repeat (40) @(negedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("colored_noise_generator_tb: done, clean");
    end else begin
      $display("colored_noise_generator_tb: done, errors");
    end
    $finish;
  end

endmodule
